// ----- rtl/c65x_pkg.sv -----
// Package for the 6502 execute unit: command codes, flag bit positions, payload structs.
// No dependencies.
package c65x_pkg;

    typedef enum logic [5:0] {
        CMD_ADC = 6'd0,  CMD_AND = 6'd1,  CMD_ASLA = 6'd2, CMD_ASLM = 6'd3,
        CMD_CMP = 6'd4,  CMD_CPX = 6'd5,  CMD_CPY = 6'd6,  CMD_DEC = 6'd7,
        CMD_DEX = 6'd8,  CMD_DEY = 6'd9,  CMD_EOR = 6'd10, CMD_INC = 6'd11,
        CMD_INX = 6'd12, CMD_INY = 6'd13, CMD_LSRM = 6'd14, CMD_LSRA = 6'd15,
        CMD_ORA = 6'd16, CMD_ROLM = 6'd17, CMD_ROLA = 6'd18, CMD_RORA = 6'd19,
        CMD_RORM = 6'd20, CMD_SBC = 6'd21, CMD_BCC = 6'd22, CMD_BCS = 6'd23,
        CMD_BEQ = 6'd24, CMD_BMI = 6'd25, CMD_BNE = 6'd26, CMD_BPL = 6'd27,
        CMD_BVC = 6'd28, CMD_BVS = 6'd29, CMD_BIT = 6'd30, CMD_BRK = 6'd31,
        CMD_JMP = 6'd32, CMD_JSR = 6'd33, CMD_PHA = 6'd34, CMD_PHP = 6'd35,
        CMD_PLA = 6'd36, CMD_PLP = 6'd37, CMD_RTI = 6'd38, CMD_RTS = 6'd39,
        CMD_IRQ = 6'd40, CMD_LDA = 6'd41, CMD_LDX = 6'd42, CMD_LDY = 6'd43,
        CMD_STA = 6'd44, CMD_STX = 6'd45, CMD_STY = 6'd46, CMD_TAX = 6'd47,
        CMD_TAY = 6'd48, CMD_TSX = 6'd49, CMD_TXA = 6'd50, CMD_TXS = 6'd51,
        CMD_TYA = 6'd52
    } t_cmd;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;

    typedef struct packed {
        logic [5:0]  command;
        logic [15:0] oper_addr;
        logic [7:0]  operand_value;
        logic [7:0]  pop_first;
        logic [7:0]  pop_second;
        logic [7:0]  pop_third;
        logic [15:0] vector_word;
        logic [15:0] next_pc;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] new_pc;
        logic [7:0]  acc_out;
        logic [7:0]  xreg_out;
        logic [7:0]  yreg_out;
        logic [7:0]  stack_out;
        logic [7:0]  flags_out;
        logic        last;
    } t_out;

endpackage

// ----- rtl/cpu_6502_execute_unit.sv -----
// Top level of the 6502 execute unit (no decimal mode).
// Depends on c65x_pkg.
//
// Usage: one decoded instruction per transaction on i_in (valid/ready).
// The instruction is registered, then executed in a single pass of logic;
// the register file updates and up to three result transactions (writes
// for stores, read-modify-writes and pushes) are queued in a result buffer.
// Results leave on o_out (valid/ready), one per cycle while the receiver is
// ready, last=1 on the final. The first result is registered in the result
// buffer after the input register. Throughput: one instruction per cycle for
// single-result commands while the receiver is ready; an instruction with k
// writes sends k results (up to 3 for brk/interrupt), set by the single result
// port. The input register can take a new instruction while the result buffer
// drains, and holds it until the buffer can take that instruction's results.
// Reset: A, X, Y = 0, SP = 0xFD, P = 0x24, all stages empty.
// Receiver stall: results hold in the buffer; while it holds results the input
// stage holds its instruction and o_in_ready drops.
module cpu_6502_execute_unit
    import c65x_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // input register
    logic r_iv;
    t_in  r_in;

    // architectural state
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;

    // result buffer: up to 3 results of one instruction
    t_out       r_res [3];
    logic [1:0] r_cnt;  // results remaining
    logic [1:0] r_idx;  // next result to send

    logic       exec;   // input register executes this cycle
    logic       out_fire;
    logic       buf_free;

    assign out_fire    = o_out_valid && i_out_ready;
    assign buf_free    = (r_cnt == 2'd0) || (r_cnt == 2'd1 && out_fire);
    assign exec        = r_iv && buf_free;
    assign o_in_ready  = !r_iv || buf_free;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out       = r_res[r_idx];

    // execution logic
    logic [7:0]  n_a, n_x, n_y, n_sp, n_p;
    logic [15:0] n_pc;
    logic [1:0]  n_wcnt;
    logic [15:0] w_addr [3];
    logic [7:0]  w_data [3];
    logic [7:0]  m, sh_in, sh_r, nz_v;
    logic        sh_c, do_nz;
    logic [8:0]  sum;
    logic [7:0]  add_m, cmp_reg;
    logic [8:0]  cmp_d;
    logic [15:0] jsr_ret, stk;
    logic [7:0]  sp_m1, sp_m2;

    always_comb begin
        m       = r_in.operand_value;
        n_a     = r_a;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_p     = r_p;
        n_pc    = r_in.next_pc;
        n_wcnt  = 2'd0;
        do_nz   = 1'b0;
        nz_v    = 8'd0;
        stk     = {8'h01, r_sp};
        sp_m1   = r_sp - 8'd1;
        sp_m2   = r_sp - 8'd2;
        jsr_ret = r_in.next_pc - 16'd1;
        for (int i = 0; i < 3; i++) begin
            w_addr[i] = 16'd0;
            w_data[i] = 8'd0;
        end

        // shared shifter: accumulator forms use A, memory forms use m
        sh_in = (r_in.command == CMD_ASLA || r_in.command == CMD_LSRA ||
                 r_in.command == CMD_ROLA || r_in.command == CMD_RORA) ? r_a : m;
        case (r_in.command)
            CMD_ASLA, CMD_ASLM: begin sh_r = {sh_in[6:0], 1'b0};      sh_c = sh_in[7]; end
            CMD_ROLA, CMD_ROLM: begin sh_r = {sh_in[6:0], r_p[FLAG_C]}; sh_c = sh_in[7]; end
            CMD_LSRA, CMD_LSRM: begin sh_r = {1'b0, sh_in[7:1]};      sh_c = sh_in[0]; end
            default:            begin sh_r = {r_p[FLAG_C], sh_in[7:1]}; sh_c = sh_in[0]; end
        endcase

        add_m = (r_in.command == CMD_SBC) ? ~m : m;
        sum   = {1'b0, r_a} + {1'b0, add_m} + {8'd0, r_p[FLAG_C]};

        cmp_reg = (r_in.command == CMD_CPX) ? r_x :
                  (r_in.command == CMD_CPY) ? r_y : r_a;
        cmp_d   = {1'b0, cmp_reg} - {1'b0, m};

        unique case (r_in.command)
            CMD_ADC, CMD_SBC: begin
                n_a = sum[7:0];
                n_p[FLAG_C] = sum[8];
                n_p[FLAG_V] = ~(r_a[7] ^ add_m[7]) & (r_a[7] ^ sum[7]);
                do_nz = 1'b1; nz_v = sum[7:0];
            end
            CMD_AND: begin n_a = r_a & m; do_nz = 1'b1; nz_v = r_a & m; end
            CMD_EOR: begin n_a = r_a ^ m; do_nz = 1'b1; nz_v = r_a ^ m; end
            CMD_ORA: begin n_a = r_a | m; do_nz = 1'b1; nz_v = r_a | m; end
            CMD_ASLA, CMD_LSRA, CMD_ROLA, CMD_RORA: begin
                n_a = sh_r; n_p[FLAG_C] = sh_c; do_nz = 1'b1; nz_v = sh_r;
            end
            CMD_ASLM, CMD_LSRM, CMD_ROLM, CMD_RORM: begin
                n_p[FLAG_C] = sh_c; do_nz = 1'b1; nz_v = sh_r;
                n_wcnt = 2'd1; w_addr[0] = r_in.oper_addr; w_data[0] = sh_r;
            end
            CMD_CMP, CMD_CPX, CMD_CPY: begin
                n_p[FLAG_C] = ~cmp_d[8]; do_nz = 1'b1; nz_v = cmp_d[7:0];
            end
            CMD_DEC, CMD_INC: begin
                nz_v = (r_in.command == CMD_DEC) ? m - 8'd1 : m + 8'd1;
                do_nz = 1'b1;
                n_wcnt = 2'd1; w_addr[0] = r_in.oper_addr; w_data[0] = nz_v;
            end
            CMD_DEX: begin n_x = r_x - 8'd1; do_nz = 1'b1; nz_v = n_x; end
            CMD_DEY: begin n_y = r_y - 8'd1; do_nz = 1'b1; nz_v = n_y; end
            CMD_INX: begin n_x = r_x + 8'd1; do_nz = 1'b1; nz_v = n_x; end
            CMD_INY: begin n_y = r_y + 8'd1; do_nz = 1'b1; nz_v = n_y; end
            CMD_BCC: if (!r_p[FLAG_C]) n_pc = r_in.oper_addr;
            CMD_BCS: if (r_p[FLAG_C])  n_pc = r_in.oper_addr;
            CMD_BEQ: if (r_p[FLAG_Z])  n_pc = r_in.oper_addr;
            CMD_BMI: if (r_p[FLAG_N])  n_pc = r_in.oper_addr;
            CMD_BNE: if (!r_p[FLAG_Z]) n_pc = r_in.oper_addr;
            CMD_BPL: if (!r_p[FLAG_N]) n_pc = r_in.oper_addr;
            CMD_BVC: if (!r_p[FLAG_V]) n_pc = r_in.oper_addr;
            CMD_BVS: if (r_p[FLAG_V])  n_pc = r_in.oper_addr;
            CMD_BIT: begin
                n_p[FLAG_V] = m[6];
                n_p[FLAG_N] = m[7];
                n_p[FLAG_Z] = (r_a & m) == 8'd0;
            end
            CMD_BRK, CMD_IRQ: begin
                n_wcnt = 2'd3;
                w_addr[0] = stk;              w_data[0] = r_in.next_pc[15:8];
                w_addr[1] = {8'h01, sp_m1};   w_data[1] = r_in.next_pc[7:0];
                w_addr[2] = {8'h01, sp_m2};
                w_data[2] = r_p;
                w_data[2][FLAG_B] = (r_in.command == CMD_BRK);
                if (r_in.command == CMD_IRQ) w_data[2][FLAG_U] = 1'b1;
                n_sp = r_sp - 8'd3;
                n_p[FLAG_I] = 1'b1;
                n_pc = r_in.vector_word;
            end
            CMD_JMP: n_pc = r_in.oper_addr;
            CMD_JSR: begin
                n_wcnt = 2'd2;
                w_addr[0] = stk;            w_data[0] = jsr_ret[15:8];
                w_addr[1] = {8'h01, sp_m1}; w_data[1] = jsr_ret[7:0];
                n_sp = sp_m2;
                n_pc = r_in.oper_addr;
            end
            CMD_PHA, CMD_PHP: begin
                n_wcnt = 2'd1;
                w_addr[0] = stk;
                w_data[0] = (r_in.command == CMD_PHA) ? r_a : (r_p | 8'h10);
                n_sp = sp_m1;
            end
            CMD_PLA: begin
                n_sp = r_sp + 8'd1; n_a = r_in.pop_first;
                do_nz = 1'b1; nz_v = r_in.pop_first;
            end
            CMD_PLP: begin
                n_sp = r_sp + 8'd1;
                n_p = (r_in.pop_first & 8'hEF) | 8'h20;
            end
            CMD_RTI: begin
                n_sp = r_sp + 8'd3;
                n_p = (r_in.pop_first & 8'hEF) | 8'h20;
                n_pc = {r_in.pop_third, r_in.pop_second};
            end
            CMD_RTS: begin
                n_sp = r_sp + 8'd2;
                n_pc = {r_in.pop_second, r_in.pop_first} + 16'd1;
            end
            CMD_LDA: begin n_a = m; do_nz = 1'b1; nz_v = m; end
            CMD_LDX: begin n_x = m; do_nz = 1'b1; nz_v = m; end
            CMD_LDY: begin n_y = m; do_nz = 1'b1; nz_v = m; end
            CMD_STA, CMD_STX, CMD_STY: begin
                n_wcnt = 2'd1; w_addr[0] = r_in.oper_addr;
                w_data[0] = (r_in.command == CMD_STA) ? r_a :
                            (r_in.command == CMD_STX) ? r_x : r_y;
            end
            CMD_TAX: begin n_x = r_a;  do_nz = 1'b1; nz_v = r_a; end
            CMD_TAY: begin n_y = r_a;  do_nz = 1'b1; nz_v = r_a; end
            CMD_TSX: begin n_x = r_sp; do_nz = 1'b1; nz_v = r_sp; end
            CMD_TXA: begin n_a = r_x;  do_nz = 1'b1; nz_v = r_x; end
            CMD_TXS: n_sp = r_x;
            CMD_TYA: begin n_a = r_y;  do_nz = 1'b1; nz_v = r_y; end
            default: ;
        endcase

        if (do_nz) begin
            n_p[FLAG_N] = nz_v[7];
            n_p[FLAG_Z] = nz_v == 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
            r_a   <= 8'd0;
            r_x   <= 8'd0;
            r_y   <= 8'd0;
            r_sp  <= SP_RESET;
            r_p   <= FLAGS_RESET;
        end else begin
            if (o_in_ready) begin
                r_iv <= i_in_valid;
                if (i_in_valid) r_in <= i_in;
            end
            if (exec) begin
                r_a   <= n_a;
                r_x   <= n_x;
                r_y   <= n_y;
                r_sp  <= n_sp;
                r_p   <= n_p;
                r_cnt <= (n_wcnt == 2'd0) ? 2'd1 : n_wcnt;
                r_idx <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                    r_res[i].write_enable  <= n_wcnt != 2'd0;
                    r_res[i].write_address <= w_addr[i];
                    r_res[i].write_data    <= w_data[i];
                    r_res[i].new_pc        <= n_pc;
                    r_res[i].acc_out       <= n_a;
                    r_res[i].xreg_out      <= n_x;
                    r_res[i].yreg_out      <= n_y;
                    r_res[i].stack_out     <= n_sp;
                    r_res[i].flags_out     <= n_p;
                    r_res[i].last          <= (n_wcnt == 2'd0) ? (i == 0)
                                              : (2'(i) == n_wcnt - 2'd1);
                end
            end else if (out_fire) begin
                r_cnt <= r_cnt - 2'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ----- test/cpu_6502_execute_unit_tb.sv -----
// Testbench for cpu_6502_execute_unit: directed and random instruction streams,
// checked against an in-bench model of the 6502 execute stage.
// Depends on c65x_pkg and the execute unit RTL.
module cpu_6502_execute_unit_tb;
    import c65x_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    cpu_6502_execute_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #4 i_clk = ~i_clk;

    // architectural state as the model sees it
    logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    t_out exp_results[$];
    int   errors = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_off = 0;
    logic [15:0] wr_adr[3];
    logic [7:0]  wr_dat[3];
    int   wr_n;

    function automatic void set_nz(logic [7:0] v);
        cpu_p[FLAG_N] = v[7];
        cpu_p[FLAG_Z] = (v == 8'h00);
    endfunction

    function automatic void push_stack(logic [7:0] v);
        if (wr_n < 3) begin
            wr_adr[wr_n] = {8'h01, cpu_sp};
            wr_dat[wr_n] = v;
            wr_n++;
        end
        cpu_sp = cpu_sp - 8'd1;
    endfunction

    function automatic void store_mem(logic [15:0] a, logic [7:0] v);
        wr_adr[0] = a;
        wr_dat[0] = v;
        wr_n = 1;
    endfunction

    // kind: 0 asl, 1 lsr, 2 rol, 3 ror
    function automatic logic [7:0] shift_rot(int kind, logic [7:0] v);
        logic [7:0] r;
        logic       cin;
        cin = cpu_p[FLAG_C];
        case (kind)
            0: r = {v[6:0], 1'b0};
            1: r = {1'b0, v[7:1]};
            2: r = {v[6:0], cin};
            default: r = {cin, v[7:1]};
        endcase
        cpu_p[FLAG_C] = (kind == 0 || kind == 2) ? v[7] : v[0];
        set_nz(r);
        return r;
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
        cpu_p[FLAG_C] = (r >= m);
        set_nz(r - m);
    endfunction

    function automatic void add_carry(logic [7:0] m);
        logic [8:0] s;
        s = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[FLAG_C]};
        cpu_p[FLAG_C] = s[8];
        cpu_p[FLAG_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ s[7]);
        cpu_a = s[7:0];
        set_nz(cpu_a);
    endfunction

    // executes one instruction and queues its expected results
    function automatic void execute_instr(t_in t);
        logic [15:0] pc, rp;
        logic [7:0]  m;
        t_out r;
        int   n;
        pc = t.next_pc;
        m = t.operand_value;
        wr_n = 0;
        case (t.command)
            CMD_ADC:  add_carry(m);
            CMD_AND:  begin cpu_a &= m; set_nz(cpu_a); end
            CMD_ASLA: cpu_a = shift_rot(0, cpu_a);
            CMD_ASLM: store_mem(t.oper_addr, shift_rot(0, m));
            CMD_CMP:  compare_reg(cpu_a, m);
            CMD_CPX:  compare_reg(cpu_x, m);
            CMD_CPY:  compare_reg(cpu_y, m);
            CMD_DEC:  begin m = m - 8'd1; set_nz(m); store_mem(t.oper_addr, m); end
            CMD_DEX:  begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
            CMD_DEY:  begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
            CMD_EOR:  begin cpu_a ^= m; set_nz(cpu_a); end
            CMD_INC:  begin m = m + 8'd1; set_nz(m); store_mem(t.oper_addr, m); end
            CMD_INX:  begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
            CMD_INY:  begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
            CMD_LSRM: store_mem(t.oper_addr, shift_rot(1, m));
            CMD_LSRA: cpu_a = shift_rot(1, cpu_a);
            CMD_ORA:  begin cpu_a |= m; set_nz(cpu_a); end
            CMD_ROLM: store_mem(t.oper_addr, shift_rot(2, m));
            CMD_ROLA: cpu_a = shift_rot(2, cpu_a);
            CMD_RORA: cpu_a = shift_rot(3, cpu_a);
            CMD_RORM: store_mem(t.oper_addr, shift_rot(3, m));
            CMD_SBC:  add_carry(~m);
            CMD_BCC:  if (!cpu_p[FLAG_C]) pc = t.oper_addr;
            CMD_BCS:  if (cpu_p[FLAG_C]) pc = t.oper_addr;
            CMD_BEQ:  if (cpu_p[FLAG_Z]) pc = t.oper_addr;
            CMD_BMI:  if (cpu_p[FLAG_N]) pc = t.oper_addr;
            CMD_BNE:  if (!cpu_p[FLAG_Z]) pc = t.oper_addr;
            CMD_BPL:  if (!cpu_p[FLAG_N]) pc = t.oper_addr;
            CMD_BVC:  if (!cpu_p[FLAG_V]) pc = t.oper_addr;
            CMD_BVS:  if (cpu_p[FLAG_V]) pc = t.oper_addr;
            CMD_BIT: begin
                cpu_p[FLAG_V] = m[6];
                cpu_p[FLAG_N] = m[7];
                cpu_p[FLAG_Z] = ((cpu_a & m) == 8'h00);
            end
            CMD_BRK, CMD_IRQ: begin
                push_stack(t.next_pc[15:8]);
                push_stack(t.next_pc[7:0]);
                if (t.command == CMD_BRK) push_stack(cpu_p | 8'h10);
                else push_stack((cpu_p & 8'hEF) | 8'h20);
                cpu_p[FLAG_I] = 1'b1;
                pc = t.vector_word;
            end
            CMD_JMP: pc = t.oper_addr;
            CMD_JSR: begin
                rp = t.next_pc - 16'd1;
                push_stack(rp[15:8]);
                push_stack(rp[7:0]);
                pc = t.oper_addr;
            end
            CMD_PHA: push_stack(cpu_a);
            CMD_PHP: push_stack(cpu_p | 8'h10);
            CMD_PLA: begin cpu_sp = cpu_sp + 8'd1; cpu_a = t.pop_first; set_nz(cpu_a); end
            CMD_PLP: begin cpu_sp = cpu_sp + 8'd1; cpu_p = (t.pop_first & 8'hEF) | 8'h20; end
            CMD_RTI: begin
                cpu_sp = cpu_sp + 8'd3;
                cpu_p = (t.pop_first & 8'hEF) | 8'h20;
                pc = {t.pop_third, t.pop_second};
            end
            CMD_RTS: begin
                cpu_sp = cpu_sp + 8'd2;
                pc = {t.pop_second, t.pop_first} + 16'd1;
            end
            CMD_LDA: begin cpu_a = m; set_nz(m); end
            CMD_LDX: begin cpu_x = m; set_nz(m); end
            CMD_LDY: begin cpu_y = m; set_nz(m); end
            CMD_STA: store_mem(t.oper_addr, cpu_a);
            CMD_STX: store_mem(t.oper_addr, cpu_x);
            CMD_STY: store_mem(t.oper_addr, cpu_y);
            CMD_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
            CMD_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
            CMD_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
            CMD_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
            CMD_TXS: cpu_sp = cpu_x;
            CMD_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
            default: ;
        endcase
        n = (wr_n > 0) ? wr_n : 1;
        for (int k = 0; k < n; k++) begin
            r.write_enable  = (wr_n > 0);
            r.write_address = (wr_n > 0) ? wr_adr[k] : 16'h0000;
            r.write_data    = (wr_n > 0) ? wr_dat[k] : 8'h00;
            r.new_pc        = pc;
            r.acc_out       = cpu_a;
            r.xreg_out      = cpu_x;
            r.yreg_out      = cpu_y;
            r.stack_out     = cpu_sp;
            r.flags_out     = cpu_p;
            r.last          = (k == n - 1);
            exp_results.push_back(r);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance,
    // with valid still high so the next transaction can follow without a gap
    task automatic send_instr(t_in t);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= t;
        i_in_valid <= 1'b1;
        // ready is stable from just after the falling edge to the rising edge
        #1;
        while (!o_in_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        execute_instr(t);
        @(negedge i_clk);
    endtask

    function automatic t_in rand_instr(int cmd);
        t_in t;
        t.command       = cmd[5:0];
        t.oper_addr     = 16'($urandom);
        t.operand_value = 8'($urandom);
        t.pop_first     = 8'($urandom);
        t.pop_second    = 8'($urandom);
        t.pop_third     = 8'($urandom);
        t.vector_word   = 16'($urandom);
        t.next_pc       = 16'($urandom);
        return t;
    endfunction

    task automatic send_cmd(int cmd, logic [7:0] val);
        t_in t;
        t = rand_instr(cmd);
        t.operand_value = val;
        send_instr(t);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(negedge i_clk);
    endtask

    // receiver ready, with random or forced stalls
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, o_out);
                errors++;
            end else begin
                e = exp_results.pop_front();
                if (o_out !== e) begin
                    $display("%0t: result mismatch, expected %h actual %h", $time, e, o_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 200000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed();
        // arithmetic extremes: carry, overflow, zero
        send_cmd(CMD_LDA, 8'h7F);
        send_cmd(CMD_ADC, 8'h01);
        send_cmd(CMD_ADC, 8'hFF);
        send_cmd(CMD_SBC, 8'h80);
        send_cmd(CMD_LDA, 8'h00);
        send_cmd(CMD_CMP, 8'hFF);
        send_cmd(CMD_BIT, 8'hC0);
        send_cmd(CMD_ROLA, 8'h00);
        send_cmd(CMD_RORM, 8'h01);
        send_cmd(CMD_DEC, 8'h00);
        send_cmd(CMD_INC, 8'hFF);
        // stack wrap: SP from 1 down through 0 to 0xFF
        send_cmd(CMD_LDX, 8'h01);
        send_cmd(CMD_TXS, 8'h00);
        send_cmd(CMD_BRK, 8'h00);
        send_cmd(CMD_IRQ, 8'h00);
        send_cmd(CMD_RTI, 8'h00);
        send_cmd(CMD_JSR, 8'h00);
        send_cmd(CMD_RTS, 8'h00);
        send_cmd(CMD_PLP, 8'h00);
        send_cmd(CMD_PHP, 8'h00);
        send_cmd(63, 8'h00);
        send_cmd(53, 8'hFF);
        send_cmd(CMD_BVS, 8'h00);
        send_cmd(CMD_TSX, 8'h00);
    endtask

    task automatic test_random(int count);
        int c;
        for (int i = 0; i < count; i++) begin
            c = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(52);
            send_instr(rand_instr(c));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 12; i++) send_instr(rand_instr($urandom_range(52)));
        drain_results();
        send_cmd(CMD_BRK, 8'h00);
        drain_results();
        send_cmd(CMD_JSR, 8'h00);
    endtask

    initial begin
        cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
        cpu_sp = SP_RESET; cpu_p = FLAGS_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        send_idle_pct = 8; recv_idle_pct = 52;
        test_random(100);
        send_idle_pct = 52; recv_idle_pct = 8;
        test_random(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(100);
        test_backpressure();
        drain_results();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && exp_results.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
